// ----- hdl/plti_pkg.sv -----
// ----------------------------------------------------------------------------
// plti_pkg
// shared widths, mode codes and status codes of the interpolation table core
// ----------------------------------------------------------------------------
`default_nettype none

package plti_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int ANGLE_W    = 16;
  localparam int VALUE_W    = 32;
  localparam int ACC_W      = 48;
  localparam int ENTRY_W    = ANGLE_W + VALUE_W;
  localparam int PROD_W     = ANGLE_W + VALUE_W;
  localparam int APROD_W    = ANGLE_W + VALUE_W + 1;
  localparam int TERM_SHIFT = 9;

  localparam int DIV_STEPS  = PROD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_CLEAR  = 2'd0;
  localparam mode_t MODE_APPEND = 2'd1;
  localparam mode_t MODE_QUERY  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OUTSIDE  = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOT_INCR = 2'd3;

endpackage

`default_nettype wire

// ----- hdl/piecewise_linear_table_interp_core.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_core
// point table in one synchronous memory, trapezoid integral, peak tracking,
// linear segment search and interpolation through a serial divider
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------
//  command  | start, busy          | mode, angle, sample_value
//  result   | done (one cycle)     | interp_value, status, integral,
//           |                      | peak_value, point_count
//
//  clear, unused mode, full append, first append, short query: answered from the idle state
//  other appends: read, multiply, add, but no add if the angle does not increase
//  query scans one point a cycle, then a multiply and the serial divider:
//  a miss scans every filled point, a hit on point j stops the scan there
//  rst is synchronous; it empties the table, the memory holds stale words
//  the receiver cannot stall: each word is valid only while done is high
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_interp_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [plti_pkg::ANGLE_W-1:0] angle,
  input  logic [plti_pkg::VALUE_W-1:0] sample_value,
  output logic                         done,
  output logic [plti_pkg::VALUE_W-1:0] interp_value,
  output logic [1:0]                   status,
  output logic [plti_pkg::ACC_W-1:0]   integral,
  output logic [plti_pkg::VALUE_W-1:0] peak_value,
  output logic [plti_pkg::CNT_W-1:0]   point_count
);
  import plti_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_APP_CHK = 6'b000010,
    S_APP_ACC = 6'b000100,
    S_SCAN    = 6'b001000,
    S_MUL     = 6'b010000,
    S_DIVW    = 6'b100000
  } state_t;

  state_t state;

  logic [ENTRY_W-1:0] mem [MAX_POINTS];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_en;

  logic [ANGLE_W-1:0] angle_q;
  logic [VALUE_W-1:0] value_q;
  logic [ENTRY_W-1:0] prev;
  logic [CNT_W-1:0]   issue_idx;
  logic [IDX_W-1:0]   rj;
  logic               rv;
  logic [ANGLE_W-1:0] dx_r;
  logic [ANGLE_W-1:0] step_r;
  logic [VALUE_W-1:0] dy_r;
  logic [VALUE_W-1:0] y0_r;
  logic               neg_r;
  logic [APROD_W-1:0] app_prod;

  logic               accept;
  logic               full;
  logic [CNT_W-1:0]   count_m1;
  logic [ANGLE_W-1:0] px;
  logic [VALUE_W-1:0] py;
  logic [VALUE_W:0]   app_sum;
  logic [ACC_W:0]     acc_sum;
  logic [ANGLE_W-1:0] x0;
  logic [ANGLE_W-1:0] x1;
  logic [VALUE_W-1:0] y0;
  logic [VALUE_W-1:0] y1;
  logic               hit;
  logic               last;
  logic               div_start;
  logic               div_done;
  logic [VALUE_W-1:0] quo;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (point_count >= CNT_W'(MAX_POINTS));
  assign count_m1  = point_count - CNT_W'(1);
  assign px        = rd_data[ENTRY_W-1:VALUE_W];
  assign py        = rd_data[VALUE_W-1:0];
  assign app_sum   = {1'b0, py} + {1'b0, value_q};
  assign acc_sum   = {1'b0, integral} + (ACC_W+1)'(app_prod[APROD_W-1:TERM_SHIFT]);
  assign x0        = prev[ENTRY_W-1:VALUE_W];
  assign y0        = prev[VALUE_W-1:0];
  assign x1        = px;
  assign y1        = py;
  assign hit       = rv && (rj != '0) && (angle_q >= x0) && (angle_q <= x1);
  assign last      = rv && ({1'b0, rj} == count_m1);
  assign div_start = (state == S_MUL);

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = count_m1[IDX_W-1:0];
    if (state == S_IDLE) begin
      rd_en = accept && (mode == MODE_APPEND);
    end else if (state == S_SCAN) begin
      rd_en   = (issue_idx < point_count);
      rd_addr = issue_idx[IDX_W-1:0];
    end
    if (state == S_APP_ACC) begin
      wr_en   = 1'b1;
      wr_addr = point_count[IDX_W-1:0];
      wr_data = {angle_q, value_q};
    end else begin
      wr_en   = accept && (mode == MODE_APPEND) && (point_count == '0);
      wr_addr = '0;
      wr_data = {angle, sample_value};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      point_count <= '0;
      integral    <= '0;
      peak_value  <= '0;
      issue_idx   <= '0;
      rv          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_CLEAR: begin
                point_count <= '0;
                integral    <= '0;
                peak_value  <= '0;
                done        <= 1'b1;
              end
              MODE_APPEND: begin
                if (full) begin
                  done <= 1'b1;
                end else if (point_count == '0) begin
                  point_count <= CNT_W'(1);
                  if (sample_value > peak_value) begin
                    peak_value <= sample_value;
                  end
                  done <= 1'b1;
                end else begin
                  state <= S_APP_CHK;
                end
              end
              MODE_QUERY: begin
                if (point_count < CNT_W'(2)) begin
                  done <= 1'b1;
                end else begin
                  issue_idx <= '0;
                  rv        <= 1'b0;
                  state     <= S_SCAN;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_APP_CHK: begin
          if (angle_q <= px) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_APP_ACC;
          end
        end
        S_APP_ACC: begin
          integral    <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
          point_count <= point_count + CNT_W'(1);
          if (value_q > peak_value) begin
            peak_value <= value_q;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          rv <= rd_en;
          if (hit) begin
            state <= S_MUL;
          end else if (last) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          angle_q      <= angle;
          value_q      <= sample_value;
          interp_value <= '0;
          case (mode)
            MODE_APPEND: status <= full ? ST_FULL : ST_OK;
            MODE_QUERY:  status <= ST_OUTSIDE;
            default:     status <= ST_OK;
          endcase
        end
      end
      S_APP_CHK: begin
        app_prod <= APROD_W'(angle_q - px) * APROD_W'(app_sum);
        status   <= (angle_q <= px) ? ST_NOT_INCR : ST_OK;
      end
      S_SCAN: begin
        if (rd_en) begin
          rj <= issue_idx[IDX_W-1:0];
        end
        if (rv) begin
          prev <= rd_data;
        end
        if (hit) begin
          dx_r   <= x1 - x0;
          step_r <= angle_q - x0;
          y0_r   <= y0;
          neg_r  <= (y1 < y0);
          dy_r   <= (y1 < y0) ? (y0 - y1) : (y1 - y0);
        end
      end
      S_DIVW: begin
        if (div_done) begin
          interp_value <= neg_r ? (y0_r - quo) : (y0_r + quo);
          status       <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  plti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (PROD_W'(step_r) * PROD_W'(dy_r)),
    .divisor  (dx_r),
    .done     (div_done),
    .quotient (quo)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count above table size");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> point_count == CNT_W'(MAX_POINTS))
    else $error("full status with room left");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> interp_value == '0)
    else $error("nonzero value on failed word");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && rv) |-> {1'b0, rj} < point_count)
    else $error("scan read beyond filled entries");

  a_div_only_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVW)
    else $error("divider finished outside wait state");
`endif

endmodule

`default_nettype wire

// ----- hdl/plti_div.sv -----
// ----------------------------------------------------------------------------
// plti_div
// restoring divider, one quotient bit per cycle over the full dividend width
// ----------------------------------------------------------------------------
`default_nettype none

module plti_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [plti_pkg::PROD_W-1:0]  dividend,
  input  logic [plti_pkg::ANGLE_W-1:0] divisor,
  output logic                         done,
  output logic [plti_pkg::VALUE_W-1:0] quotient
);
  import plti_pkg::*;

  logic                 active;
  logic [DIV_CNT_W-1:0] step_cnt;
  logic [PROD_W-1:0]    q;
  logic [ANGLE_W-1:0]   rem;
  logic [ANGLE_W-1:0]   rem_next;
  logic [ANGLE_W:0]     trial;
  logic                 ge;

  always_comb begin
    trial    = {rem, q[PROD_W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? ANGLE_W'(trial - {1'b0, divisor}) : trial[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        step_cnt <= '0;
      end else if (active) begin
        step_cnt <= step_cnt + DIV_CNT_W'(1);
        if (step_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (active) begin
      q   <= {q[PROD_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = q[VALUE_W-1:0];

endmodule

`default_nettype wire

// ----- bench/plti_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_table_checker
// watches the command and result channels of the interpolation table core,
// keeps its own copy of the point table, integral and peak, works out the
// result word of every accepted command and compares it field by field with
// the words that come back, in order
// ----------------------------------------------------------------------------

module plti_table_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [plti_pkg::ANGLE_W-1:0] angle,
  input  logic [plti_pkg::VALUE_W-1:0] sample_value,
  input  logic                         done,
  input  logic [plti_pkg::VALUE_W-1:0] interp_value,
  input  logic [1:0]                   status,
  input  logic [plti_pkg::ACC_W-1:0]   integral,
  input  logic [plti_pkg::VALUE_W-1:0] peak_value,
  input  logic [plti_pkg::CNT_W-1:0]   point_count,
  output int                           fail_count,
  output int                           outstanding
);
  import plti_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] interp;
    status_t            st;
    logic [ACC_W-1:0]   area;
    logic [VALUE_W-1:0] peak;
    logic [CNT_W-1:0]   count;
  } table_word_t;

  logic [ANGLE_W-1:0] x_tab [MAX_POINTS];
  logic [VALUE_W-1:0] y_tab [MAX_POINTS];
  logic [CNT_W-1:0]   n_pts;
  logic [ACC_W-1:0]   area_acc;
  logic [VALUE_W-1:0] peak_hold;

  table_word_t expected_words [$];

  initial fail_count = 0;
  initial outstanding = 0;

  function automatic table_word_t predict_word(logic [1:0] m, logic [ANGLE_W-1:0] a,
                                               logic [VALUE_W-1:0] v);
    table_word_t        w;
    logic [APROD_W-1:0] trap;
    logic [ACC_W+1:0]   area_sum;
    logic [PROD_W-1:0]  slope_prod;
    logic [PROD_W-1:0]  slope_q;
    logic [ANGLE_W-1:0] span;
    logic [ANGLE_W-1:0] offs;
    logic [VALUE_W-1:0] y0;
    logic [VALUE_W-1:0] y1;
    logic [IDX_W-1:0]   last_i;
    bit                 hit;
    w = '0;
    w.st = ST_OK;
    hit = 1'b0;
    last_i = IDX_W'(n_pts - 1'b1);
    case (m)
      MODE_CLEAR: begin
        n_pts = '0;
        area_acc = '0;
        peak_hold = '0;
      end
      MODE_APPEND: begin
        if (n_pts >= MAX_POINTS) begin
          w.st = ST_FULL;
        end else if (n_pts != 0 && a <= x_tab[last_i]) begin
          w.st = ST_NOT_INCR;
        end else begin
          if (n_pts != 0) begin
            // trapezoid: dx * (y_prev + y), halved and rescaled to Q32.16
            trap = (a - x_tab[last_i]) * (y_tab[last_i] + v);
            area_sum = area_acc + (trap >> TERM_SHIFT);
            if (area_sum > {ACC_W{1'b1}}) area_acc = '1;
            else area_acc = area_sum[ACC_W-1:0];
          end
          x_tab[n_pts[IDX_W-1:0]] = a;
          y_tab[n_pts[IDX_W-1:0]] = v;
          n_pts = n_pts + 1'b1;
          if (v > peak_hold) peak_hold = v;
        end
      end
      MODE_QUERY: begin
        w.st = ST_OUTSIDE;
        for (int i = 1; i < n_pts; i++) begin
          if (!hit && a >= x_tab[i-1] && a <= x_tab[i]) begin
            hit = 1'b1;
            w.st = ST_OK;
            y0 = y_tab[i-1];
            y1 = y_tab[i];
            span = x_tab[i] - x_tab[i-1];
            offs = a - x_tab[i-1];
            if (span == 0) begin
              w.interp = y0;
            end else if (y1 >= y0) begin
              slope_prod = offs * (y1 - y0);
              slope_q = slope_prod / span;
              w.interp = y0 + slope_q[VALUE_W-1:0];
            end else begin
              slope_prod = offs * (y0 - y1);
              slope_q = slope_prod / span;
              w.interp = y0 - slope_q[VALUE_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    w.area = area_acc;
    w.peak = peak_hold;
    w.count = n_pts;
    return w;
  endfunction

  function automatic void check_field(string name, logic [ACC_W-1:0] want,
                                      logic [ACC_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    table_word_t w;
    if (rst) begin
      n_pts = '0;
      area_acc = '0;
      peak_hold = '0;
      expected_words.delete();
    end else begin
      // the word leaving now always belongs to an older command
      if (done) begin
        if (expected_words.size() == 0) begin
          $error("result word with no command pending");
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          check_field("interp_value", w.interp, interp_value);
          check_field("status", w.st, status);
          check_field("integral", w.area, integral);
          check_field("peak_value", w.peak, peak_value);
          check_field("point_count", w.count, point_count);
        end
      end
      if (start && !busy) expected_words.push_back(predict_word(mode, angle, sample_value));
    end
    outstanding <= expected_words.size();
  end

endmodule

// ----- bench/tb_piecewise_linear_table_interp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interp_core
// drives clear, append, query and unused-mode commands into the table core:
// a directed opening over the edge cases, then random tables built in
// increasing angle order with queries inside, on and outside the points,
// one table filled to capacity, and random sender gaps; the checker beside
// the core predicts and compares every result word
// ----------------------------------------------------------------------------

module tb_piecewise_linear_table_interp_core;
  import plti_pkg::*;

  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int    N_ITEMS     = 700;
  localparam int    QUIET_TAIL  = 100;
  localparam int    CYCLE_LIMIT = 1_000_000;
  localparam int    ANGLE_MAX   = 65535;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         mode = '0;
  logic [ANGLE_W-1:0] angle = '0;
  logic [VALUE_W-1:0] sample_value = '0;
  logic               busy;
  logic               done;
  logic [VALUE_W-1:0] interp_value;
  logic [1:0]         status;
  logic [ACC_W-1:0]   integral;
  logic [VALUE_W-1:0] peak_value;
  logic [CNT_W-1:0]   point_count;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int sent = 0;
  bit gaps_on = 1'b1;
  int pts_x [$];

  always #4 clk = ~clk;

  piecewise_linear_table_interp_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .angle(angle),
    .sample_value(sample_value),
    .done(done),
    .interp_value(interp_value),
    .status(status),
    .integral(integral),
    .peak_value(peak_value),
    .point_count(point_count)
  );

  plti_table_checker checker_i (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .angle(angle),
    .sample_value(sample_value),
    .done(done),
    .interp_value(interp_value),
    .status(status),
    .integral(integral),
    .peak_value(peak_value),
    .point_count(point_count),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 255);
      3: return 32'hFFFF_FF00 | $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // called right after a rising edge; returns at the edge that takes the word
  task automatic push_word(logic [1:0] m, logic [ANGLE_W-1:0] a, logic [VALUE_W-1:0] v);
    if (gaps_on && sent < N_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    angle <= a;
    sample_value <= v;
    do @(posedge clk); while (busy);
    if (m != MODE_UNUSED) sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int round;
    int npts;
    int lo;
    int span_max;
    int a_next;
    int a_q;
    int lo_x;
    int hi_x;
    round = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening
    push_word(MODE_QUERY, 16'h0000, 32'h0000_0000);
    push_word(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    push_word(MODE_APPEND, 16'h0000, 32'hFFFF_FFFF);
    push_word(MODE_QUERY, 16'h0000, 32'h0000_0000);
    push_word(MODE_APPEND, 16'h0000, 32'h0000_0005);
    push_word(MODE_APPEND, 16'h0100, 32'h0000_0000);
    push_word(MODE_APPEND, 16'h0080, 32'h0000_0007);
    push_word(MODE_APPEND, 16'hFFFF, 32'hFFFF_FFFF);
    push_word(MODE_QUERY, 16'h0000, 32'hFFFF_FFFF);
    push_word(MODE_QUERY, 16'h0100, 32'h0000_0000);
    push_word(MODE_QUERY, 16'hFFFF, 32'h0000_0000);
    push_word(MODE_QUERY, 16'h0040, 32'h0000_0000);
    push_word(MODE_QUERY, 16'h8000, 32'h0000_0000);
    push_word(MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    push_word(MODE_QUERY, 16'h8000, 32'h0000_0000);
    push_word(MODE_APPEND, 16'h1000, 32'h1234_5678);
    push_word(MODE_APPEND, 16'h1001, 32'h1234_5679);
    push_word(MODE_APPEND, 16'h2000, 32'h0000_0001);
    push_word(MODE_QUERY, 16'h0FFF, 32'h0000_0000);
    push_word(MODE_QUERY, 16'h2001, 32'h0000_0000);
    push_word(MODE_QUERY, 16'h1800, 32'h0000_0000);
    push_word(MODE_QUERY, 16'h1001, 32'h0000_0000);
    push_word(MODE_UNUSED, 16'h0000, 32'h0000_0000);
    push_word(MODE_CLEAR, 16'h0000, 32'h0000_0000);

    // random tables
    while (sent < N_ITEMS) begin
      round++;
      gaps_on = $urandom_range(0, 2) != 0;
      if (round == 1 || $urandom_range(0, 7) == 0) wait_drained();
      push_word(MODE_CLEAR, ANGLE_W'($urandom), $urandom);
      if (round == 3) npts = MAX_POINTS;
      else if ($urandom_range(0, 9) == 0) npts = $urandom_range(0, 1);
      else npts = $urandom_range(2, 12);
      pts_x.delete();

      if (npts > 0) begin
        if (npts == MAX_POINTS) lo = $urandom_range(0, 255);
        else lo = $urandom_range(0, ANGLE_MAX - npts);
        span_max = (ANGLE_MAX - lo) / npts;
        if ($urandom_range(0, 3) == 0 && span_max > 4) span_max = 4;
        a_next = lo;
        for (int k = 0; k < npts; k++) begin
          if (k != 0) a_next = a_next + $urandom_range(1, span_max);
          push_word(MODE_APPEND, ANGLE_W'(a_next), pick_sample());
          pts_x.push_back(a_next);
          case ($urandom_range(0, 9))
            0: push_word(MODE_APPEND, ANGLE_W'($urandom_range(0, a_next)), pick_sample());
            1, 2: push_word(MODE_QUERY, ANGLE_W'($urandom_range(pts_x[0], a_next)),
                            $urandom);
            default: ;
          endcase
        end
      end
      if (npts == MAX_POINTS) begin
        repeat (2) push_word(MODE_APPEND, ANGLE_W'($urandom), pick_sample());
      end

      repeat ($urandom_range(3, 10)) begin
        a_q = $urandom_range(0, ANGLE_MAX);
        if (pts_x.size() != 0) begin
          lo_x = pts_x[0];
          hi_x = pts_x[$];
          case ($urandom_range(0, 9))
            0, 1, 2, 3: a_q = $urandom_range(lo_x, hi_x);
            4, 5, 6: a_q = pts_x[$urandom_range(0, pts_x.size() - 1)];
            7, 8: begin
              if (lo_x > 0) a_q = $urandom_range(0, lo_x - 1);
              else if (hi_x < ANGLE_MAX) a_q = $urandom_range(hi_x + 1, ANGLE_MAX);
            end
            default: ;
          endcase
        end
        if ($urandom_range(0, 9) == 0) push_word(MODE_UNUSED, ANGLE_W'(a_q), $urandom);
        else push_word(MODE_QUERY, ANGLE_W'(a_q), $urandom);
      end
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
